### rtl/core/wwsa_pkg.sv
// wwsa_pkg: shared types and constants for the wide word stack ALU.
// Holds the transaction structs, operation and status codes, and controller commands.
// No dependencies.
package wwsa_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int LIMB_W      = 64;
    localparam int LIMBS       = 4;
    localparam int WORD_W      = LIMB_W * LIMBS;
    localparam int DEPTH_OUT_W = 11;

    typedef enum logic [2:0] {
        OP_PUSH = 3'd0,
        OP_READ = 3'd1,
        OP_POP  = 3'd2,
        OP_ADD  = 3'd3,
        OP_SUB  = 3'd4,
        OP_DUP  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_UNDER = 2'd1,
        STAT_OVER  = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    // write data source for the stack memory
    typedef enum logic [1:0] {
        WSRC_IN,
        WSRC_TOP,
        WSRC_SUM
    } wsrc_t;

    // load source for the cached top word
    typedef enum logic [1:0] {
        TSRC_IN,
        TSRC_RD,
        TSRC_SUM
    } tsrc_t;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [LIMB_W-1:0] data_limb_0;
        logic [LIMB_W-1:0] data_limb_1;
        logic [LIMB_W-1:0] data_limb_2;
        logic [LIMB_W-1:0] data_limb_3;
    } req_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [LIMB_W-1:0]      top_limb_0;
        logic [LIMB_W-1:0]      top_limb_1;
        logic [LIMB_W-1:0]      top_limb_2;
        logic [LIMB_W-1:0]      top_limb_3;
        logic [DEPTH_OUT_W-1:0] depth_now;
    } rsp_t;

    typedef struct packed {
        logic              mem_we;
        logic [ADDR_W-1:0] waddr;
        wsrc_t             wsrc;
        logic [ADDR_W-1:0] raddr;
        logic              top_we;
        tsrc_t             tsrc;
        logic              sub;
        logic              res_load;
        status_t           res_status;
        logic              res_show_top;
        logic [CNT_W-1:0]  res_depth;
    } dp_cmd_t;

endpackage

### rtl/core/wwsa_ctrl.sv
// wwsa_ctrl: controller for the wide word stack ALU.
// Tracks the entry count, checks bounds and sequences the datapath.
// Depends on wwsa_pkg.
module wwsa_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [2:0]        req_type,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output wwsa_pkg::dp_cmd_t cmd
);

    wwsa_pkg::ctrl_state_t          state_reg, state_next;
    logic [wwsa_pkg::CNT_W-1:0]     count_reg, count_next;
    wwsa_pkg::op_t                  op_reg, op_next;
    logic                           out_valid_reg, out_valid_next;

    wwsa_pkg::op_t                  op_in;
    logic                           accept;
    logic                           out_busy;
    logic                           is_empty;
    logic                           is_full;
    logic                           below_two;
    logic                           needs_exec;
    logic [wwsa_pkg::CNT_W-1:0]     cnt_m1;
    logic [wwsa_pkg::CNT_W-1:0]     cnt_m2;
    logic [wwsa_pkg::CNT_W-1:0]     cnt_p1;

    assign op_in     = wwsa_pkg::op_t'(req_type);
    assign out_busy  = out_valid_reg && rsp_stall;
    assign req_stall = (state_reg != wwsa_pkg::ST_IDLE) || out_busy;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = out_valid_reg;

    assign cnt_m1    = count_reg - wwsa_pkg::CNT_W'(1);
    assign cnt_m2    = count_reg - wwsa_pkg::CNT_W'(2);
    assign cnt_p1    = count_reg + wwsa_pkg::CNT_W'(1);
    assign is_empty  = (count_reg == '0);
    assign below_two = (count_reg < wwsa_pkg::CNT_W'(2));
    assign is_full   = (count_reg >= wwsa_pkg::CNT_W'(wwsa_pkg::STACK_DEPTH));

    // pop, add and sub need the second entry from memory first
    always_comb
    begin
        case (op_in)
            wwsa_pkg::OP_POP:  needs_exec = !is_empty;
            wwsa_pkg::OP_ADD,
            wwsa_pkg::OP_SUB:  needs_exec = !below_two;
            default:           needs_exec = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wwsa_pkg::ST_IDLE:
            begin
                if (accept && needs_exec)
                    state_next = wwsa_pkg::ST_EXEC;
            end
            wwsa_pkg::ST_EXEC:
            begin
                state_next = wwsa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = wwsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.wsrc       = wwsa_pkg::WSRC_IN;
        cmd.tsrc       = wwsa_pkg::TSRC_IN;
        cmd.res_status = wwsa_pkg::STAT_DONE;
        cmd.raddr      = cnt_m2[wwsa_pkg::ADDR_W-1:0];
        count_next     = count_reg;
        op_next        = op_reg;
        out_valid_next = out_busy;

        case (state_reg)
            wwsa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next      = op_in;
                    cmd.res_load = !needs_exec;
                    case (op_in)
                        wwsa_pkg::OP_PUSH:
                        begin
                            if (is_full)
                                cmd.res_status = wwsa_pkg::STAT_OVER;
                            else
                            begin
                                cmd.mem_we = 1'b1;
                                cmd.waddr  = count_reg[wwsa_pkg::ADDR_W-1:0];
                                cmd.wsrc   = wwsa_pkg::WSRC_IN;
                                cmd.top_we = 1'b1;
                                cmd.tsrc   = wwsa_pkg::TSRC_IN;
                                count_next = cnt_p1;
                            end
                        end
                        wwsa_pkg::OP_READ:
                        begin
                            if (is_empty)
                                cmd.res_status = wwsa_pkg::STAT_UNDER;
                            else
                                cmd.res_show_top = 1'b1;
                        end
                        wwsa_pkg::OP_POP:
                        begin
                            if (is_empty)
                                cmd.res_status = wwsa_pkg::STAT_UNDER;
                            else
                                count_next = cnt_m1;
                        end
                        wwsa_pkg::OP_ADD,
                        wwsa_pkg::OP_SUB:
                        begin
                            if (below_two)
                                cmd.res_status = wwsa_pkg::STAT_UNDER;
                            else
                                count_next = cnt_m1;
                        end
                        wwsa_pkg::OP_DUP:
                        begin
                            if (is_empty)
                                cmd.res_status = wwsa_pkg::STAT_UNDER;
                            else if (is_full)
                                cmd.res_status = wwsa_pkg::STAT_OVER;
                            else
                            begin
                                cmd.mem_we = 1'b1;
                                cmd.waddr  = count_reg[wwsa_pkg::ADDR_W-1:0];
                                cmd.wsrc   = wwsa_pkg::WSRC_TOP;
                                count_next = cnt_p1;
                            end
                        end
                        default:
                        begin
                            // undefined code: ignored, reported as done
                            cmd.res_status = wwsa_pkg::STAT_DONE;
                        end
                    endcase
                    if (cmd.res_load)
                        out_valid_next = 1'b1;
                end
            end
            wwsa_pkg::ST_EXEC:
            begin
                // count already holds the new depth; second entry sits at count - 1
                cmd.res_load   = 1'b1;
                out_valid_next = 1'b1;
                if (op_reg == wwsa_pkg::OP_POP)
                begin
                    cmd.top_we = 1'b1;
                    cmd.tsrc   = wwsa_pkg::TSRC_RD;
                end
                else
                begin
                    cmd.mem_we = 1'b1;
                    cmd.waddr  = cnt_m1[wwsa_pkg::ADDR_W-1:0];
                    cmd.wsrc   = wwsa_pkg::WSRC_SUM;
                    cmd.top_we = 1'b1;
                    cmd.tsrc   = wwsa_pkg::TSRC_SUM;
                    cmd.sub    = (op_reg == wwsa_pkg::OP_SUB);
                end
            end
            default:
            begin
                out_valid_next = out_busy;
            end
        endcase

        cmd.res_depth = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wwsa_pkg::ST_IDLE;
            count_reg     <= '0;
            op_reg        <= wwsa_pkg::OP_PUSH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/core/wwsa_datapath.sv
// wwsa_datapath: stack memory, cached top word, 256-bit adder and result register.
// Driven by the command struct from wwsa_ctrl.
// Depends on wwsa_pkg.
module wwsa_datapath
(
    input  logic              clk,
    input  wwsa_pkg::req_t    req,
    input  wwsa_pkg::dp_cmd_t cmd,
    output wwsa_pkg::rsp_t    rsp
);

    logic [wwsa_pkg::WORD_W-1:0] mem [wwsa_pkg::STACK_DEPTH];
    logic [wwsa_pkg::WORD_W-1:0] rdata_reg;
    logic [wwsa_pkg::WORD_W-1:0] top_reg;
    wwsa_pkg::rsp_t              rsp_reg;

    logic [wwsa_pkg::WORD_W-1:0] in_word;
    logic [wwsa_pkg::WORD_W-1:0] operand;
    logic [wwsa_pkg::WORD_W-1:0] sum;
    logic [wwsa_pkg::WORD_W-1:0] wdata;
    logic [wwsa_pkg::WORD_W-1:0] top_in;

    assign in_word = {req.data_limb_3, req.data_limb_2, req.data_limb_1, req.data_limb_0};

    // sub is top + ~second + 1
    assign operand = cmd.sub ? ~rdata_reg : rdata_reg;
    assign sum     = top_reg + operand + wwsa_pkg::WORD_W'(cmd.sub);

    always_comb
    begin
        case (cmd.wsrc)
            wwsa_pkg::WSRC_IN:  wdata = in_word;
            wwsa_pkg::WSRC_TOP: wdata = top_reg;
            wwsa_pkg::WSRC_SUM: wdata = sum;
            default:            wdata = in_word;
        endcase
    end

    always_comb
    begin
        case (cmd.tsrc)
            wwsa_pkg::TSRC_IN:  top_in = in_word;
            wwsa_pkg::TSRC_RD:  top_in = rdata_reg;
            wwsa_pkg::TSRC_SUM: top_in = sum;
            default:            top_in = in_word;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
            mem[cmd.waddr] <= wdata;
        rdata_reg <= mem[cmd.raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.top_we)
            top_reg <= top_in;
        if (cmd.res_load)
        begin
            rsp_reg.status <= cmd.res_status;
            if (cmd.res_show_top)
            begin
                rsp_reg.top_limb_0 <= top_reg[0*wwsa_pkg::LIMB_W +: wwsa_pkg::LIMB_W];
                rsp_reg.top_limb_1 <= top_reg[1*wwsa_pkg::LIMB_W +: wwsa_pkg::LIMB_W];
                rsp_reg.top_limb_2 <= top_reg[2*wwsa_pkg::LIMB_W +: wwsa_pkg::LIMB_W];
                rsp_reg.top_limb_3 <= top_reg[3*wwsa_pkg::LIMB_W +: wwsa_pkg::LIMB_W];
            end
            else
            begin
                rsp_reg.top_limb_0 <= '0;
                rsp_reg.top_limb_1 <= '0;
                rsp_reg.top_limb_2 <= '0;
                rsp_reg.top_limb_3 <= '0;
            end
            rsp_reg.depth_now <= wwsa_pkg::DEPTH_OUT_W'(cmd.res_depth);
        end
    end

    assign rsp = rsp_reg;

endmodule

### rtl/core/wide_word_stack_alu.sv
// wide_word_stack_alu: top level of the 256-bit stack ALU.
// Joins wwsa_ctrl and wwsa_datapath; depends on wwsa_pkg.
//
// A stack of up to 1024 256-bit words with push, read, pop, add, sub and dup,
// one operation per request transaction and one response per request. The top
// word is cached in a register, so push, read, dup, rejected and undefined
// operations load the response register when accepted; pop, add and sub pass
// through ST_EXEC, as the second entry comes through the single registered
// read port of the memory before the sum or new top is formed. A new request
// is taken in ST_IDLE when the response register is free or being emptied in
// the same cycle. Operations that would underflow or overflow leave the stack
// untouched and report it in status. The memory needs no clearing after reset.
module wide_word_stack_alu
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  wwsa_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output wwsa_pkg::rsp_t  rsp
);

    wwsa_pkg::dp_cmd_t cmd;

    wwsa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    wwsa_datapath u_datapath
    (
        .clk (clk),
        .req (req),
        .cmd (cmd),
        .rsp (rsp)
    );

endmodule
